// ----- rtl/cau_pkg.sv -----
package cau_pkg;

    localparam int DW        = 16;              // operand part width
    localparam int FRAC_BITS = 8;               // fraction bits
    localparam int PW        = 2 * DW;          // product width
    localparam int MW        = PW + 1;          // sum magnitude width
    localparam int QW        = DW + 1;          // quotient bits, one per cell
    localparam int RW        = (MW + FRAC_BITS > PW + QW) ? MW + FRAC_BITS : PW + QW;
    localparam int CIW       = $clog2(QW);      // cell bit index width
    localparam int OPW       = 3;

    localparam int IN_FW     = OPW + 4 * DW;
    localparam int IN_TW     = ((IN_FW + 7) / 8) * 8;
    localparam int OUT_FW    = 2 * DW + 3;
    localparam int OUT_TW    = ((OUT_FW + 7) / 8) * 8;

    localparam logic [MW-1:0] SIGN_MAG = MW'(1) << (DW - 1);
    localparam logic [MW-1:0] POS_MAX  = SIGN_MAG - MW'(1);

    typedef enum logic [OPW-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_NE  = 3'd5
    } t_op;

    typedef struct packed {
        logic          sat;
        logic [DW-1:0] val;
    } t_sat;

    typedef struct packed {
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic          cmp;
        logic          sat;
        logic          dz;
    } t_res;

    typedef struct packed {
        logic                 is_div;
        logic signed [PW-1:0] p_rr;   // a_re * b_re
        logic signed [PW-1:0] p_ii;   // a_im * b_im
        logic signed [PW-1:0] p_ir;   // a_im * b_re
        logic signed [PW-1:0] p_ri;   // a_re * b_im
        logic signed [PW-1:0] p_bb;   // b_re * b_re
        logic signed [PW-1:0] p_cc;   // b_im * b_im
        logic                 is_mul;
        t_res                 res;
    } t_prod;

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [RW-1:0] rem;
        logic [QW-1:0] q;
    } t_lane;

    typedef struct packed {
        logic          is_div;
        logic [PW-1:0] d;
        t_lane         re;
        t_lane         im;
        t_res          res;
    } t_item;

    // Clip a sign/magnitude value to the signed DW range.
    function automatic t_sat sat_sm(input logic neg, input logic [MW-1:0] mag);
        t_sat r;
        r.sat = 1'b0;
        r.val = mag[DW-1:0];
        if (!neg) begin
            if (mag > POS_MAX) begin
                r.sat = 1'b1;
                r.val = {1'b0, {(DW-1){1'b1}}};
            end
        end else if (mag > SIGN_MAG) begin
            r.sat = 1'b1;
            r.val = {1'b1, {(DW-1){1'b0}}};
        end else begin
            r.val = -mag[DW-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/cau_prod.sv -----
module cau_prod (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [cau_pkg::OPW-1:0] i_op,
    input  logic [cau_pkg::DW-1:0] i_a_re,
    input  logic [cau_pkg::DW-1:0] i_a_im,
    input  logic [cau_pkg::DW-1:0] i_b_re,
    input  logic [cau_pkg::DW-1:0] i_b_im,
    output logic                   o_valid,
    input  logic                   i_ready,
    output cau_pkg::t_prod         o_prod
);
    import cau_pkg::*;

    logic                 r_valid;
    t_prod                r_prod;
    t_prod                n_prod;
    logic signed [DW-1:0] ar, ai, br, bi;
    logic signed [DW:0]   s_re, s_im;
    logic                 sub;
    t_sat                 sr, si;

    assign ar = $signed(i_a_re);
    assign ai = $signed(i_a_im);
    assign br = $signed(i_b_re);
    assign bi = $signed(i_b_im);
    assign sub = (t_op'(i_op) == OP_SUB);

    always_comb begin
        s_re = sub ? (DW+1)'(ar) - (DW+1)'(br) : (DW+1)'(ar) + (DW+1)'(br);
        s_im = sub ? (DW+1)'(ai) - (DW+1)'(bi) : (DW+1)'(ai) + (DW+1)'(bi);
        sr = sat_sm(s_re[DW], MW'(s_re[DW] ? -s_re : s_re));
        si = sat_sm(s_im[DW], MW'(s_im[DW] ? -s_im : s_im));
    end

    always_comb begin
        n_prod        = '0;
        n_prod.p_rr   = ar * br;
        n_prod.p_ii   = ai * bi;
        n_prod.p_ir   = ai * br;
        n_prod.p_ri   = ar * bi;
        n_prod.p_bb   = br * br;
        n_prod.p_cc   = bi * bi;
        case (t_op'(i_op))
            OP_ADD, OP_SUB: begin
                n_prod.res.re  = sr.val;
                n_prod.res.im  = si.val;
                n_prod.res.sat = sr.sat | si.sat;
            end
            OP_MUL: n_prod.is_mul = 1'b1;
            OP_DIV: n_prod.is_div = 1'b1;
            OP_EQ:  n_prod.res.cmp = (ar == br) && (ai == bi);
            OP_NE:  n_prod.res.cmp = (ar != br) || (ai != bi);
            default: ;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_prod  = r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

endmodule

// ----- rtl/cau_sum.sv -----
module cau_sum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cau_pkg::t_prod i_prod,
    output logic           o_valid,
    input  logic           i_ready,
    output cau_pkg::t_item o_item
);
    import cau_pkg::*;

    logic                 r_valid;
    t_item                r_item;
    t_item                n_item;
    logic signed [MW-1:0] s_re, s_im;
    logic [MW-1:0]        m_re, m_im;
    logic [PW-1:0]        d;
    logic [RW-1:0]        d_top;
    t_sat                 sr, si;

    always_comb begin
        if (i_prod.is_div) begin
            s_re = MW'(i_prod.p_rr) + MW'(i_prod.p_ii);
            s_im = MW'(i_prod.p_ir) - MW'(i_prod.p_ri);
        end else begin
            s_re = MW'(i_prod.p_rr) - MW'(i_prod.p_ii);
            s_im = MW'(i_prod.p_ir) + MW'(i_prod.p_ri);
        end
        m_re  = s_re[MW-1] ? -s_re : s_re;
        m_im  = s_im[MW-1] ? -s_im : s_im;
        d     = PW'(i_prod.p_bb) + PW'(i_prod.p_cc);
        d_top = RW'(d) << QW;
        sr    = sat_sm(s_re[MW-1], m_re >> FRAC_BITS);
        si    = sat_sm(s_im[MW-1], m_im >> FRAC_BITS);

        n_item        = '0;
        n_item.res    = i_prod.res;
        n_item.d      = d;
        n_item.re.neg = s_re[MW-1];
        n_item.im.neg = s_im[MW-1];
        n_item.re.rem = RW'(m_re) << FRAC_BITS;
        n_item.im.rem = RW'(m_im) << FRAC_BITS;
        n_item.re.ovf = (RW'(m_re) << FRAC_BITS) >= d_top;
        n_item.im.ovf = (RW'(m_im) << FRAC_BITS) >= d_top;
        if (i_prod.is_mul) begin
            n_item.res.re  = sr.val;
            n_item.res.im  = si.val;
            n_item.res.sat = sr.sat | si.sat;
        end
        if (i_prod.is_div) begin
            // zero divisor: report it and drop the quotient
            if (d == '0) begin
                n_item.res.dz = 1'b1;
            end else begin
                n_item.is_div = 1'b1;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/cau_cell.sv -----
module cau_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [cau_pkg::CIW-1:0] i_bit,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  cau_pkg::t_item          i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output cau_pkg::t_item          o_item
);
    import cau_pkg::*;

    logic          r_valid;
    t_item         r_item;
    t_item         n_item;
    logic [RW-1:0] dsh;
    logic          ge_re, ge_im;

    // One restoring step per lane: try the divisor shifted to this bit.
    always_comb begin
        dsh    = RW'(i_item.d) << i_bit;
        ge_re  = i_item.re.rem >= dsh;
        ge_im  = i_item.im.rem >= dsh;
        n_item = i_item;
        if (ge_re) begin
            n_item.re.rem = i_item.re.rem - dsh;
            n_item.re.q   = i_item.re.q | (QW'(1) << i_bit);
        end
        if (ge_im) begin
            n_item.im.rem = i_item.im.rem - dsh;
            n_item.im.q   = i_item.im.q | (QW'(1) << i_bit);
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// Each result passes the multiply stage, the combine stage, 17 divider cells and the
// output register in order; every operation takes the same path.
// Throughput: one item per cycle while the sink accepts; each stage holds one item and advances when
// the stage after it is empty or moving, so bubbles close up under backpressure.
// Reset: i_rst_n synchronous, active low; clears all stage valid bits.
module complex_arithmetic_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // op[2:0], a_re[18:3], a_im[34:19], b_re[50:35], b_im[66:51], zero pad
    input  logic [cau_pkg::IN_TW-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // res_re[15:0], res_im[31:16], cmp_flag[32], saturated[33], div_zero[34], zero pad
    output logic [cau_pkg::OUT_TW-1:0]  m_axis_tdata
);
    import cau_pkg::*;

    // Front stages: products, then sums / magnitudes / divider setup.
    logic  p_valid, p_ready;
    t_prod p_prod;

    // chain[0] is the combine stage output, chain[g+1] the output of cell g
    logic  c_valid [QW+1];
    logic  c_ready [QW+1];
    t_item c_item  [QW+1];

    logic  out_ready;
    logic  r_out_valid;
    t_res  r_out;
    t_res  n_out;
    t_sat  qr, qi;
    t_item last;

    cau_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tdata[OPW-1:0]),
        .i_a_re  (s_axis_tdata[OPW +: DW]),
        .i_a_im  (s_axis_tdata[OPW+DW +: DW]),
        .i_b_re  (s_axis_tdata[OPW+2*DW +: DW]),
        .i_b_im  (s_axis_tdata[OPW+3*DW +: DW]),
        .o_valid (p_valid),
        .i_ready (p_ready),
        .o_prod  (p_prod)
    );

    cau_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p_valid),
        .o_ready (p_ready),
        .i_prod  (p_prod),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_item  (c_item[0])
    );

    // Divider row: cell g resolves quotient bit QW-1-g for both lanes and
    // passes every item on, divide or not.
    for (genvar g = 0; g < QW; g++) begin : g_cell
        cau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bit   (CIW'(QW - 1 - g)),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_item  (c_item[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_item  (c_item[g+1])
        );
    end

    assign last = c_item[QW];

    // Final clip of the quotients; a lane that overflowed the row saturates.
    always_comb begin
        qr    = sat_sm(last.re.neg, last.re.ovf ? '1 : MW'(last.re.q));
        qi    = sat_sm(last.im.neg, last.im.ovf ? '1 : MW'(last.im.q));
        n_out = last.res;
        if (last.is_div) begin
            n_out.re  = qr.val;
            n_out.im  = qi.val;
            n_out.sat = qr.sat | qi.sat;
        end
    end

    assign out_ready  = !r_out_valid || m_axis_tready;
    assign c_ready[QW] = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= c_valid[QW];
        end
    end

    // Hold the result while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (out_ready && c_valid[QW]) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TW-OUT_FW)'(0), r_out.dz, r_out.sat, r_out.cmp,
                            r_out.im, r_out.re};

endmodule

// ----- rtl/cau_checker.sv -----
module cau_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [cau_pkg::OUT_TW-1:0] m_axis_tdata
);
    import cau_pkg::*;

    logic          cmp, sat, dz;
    logic [DW-1:0] re, im;

    assign re  = m_axis_tdata[DW-1:0];
    assign im  = m_axis_tdata[2*DW-1:DW];
    assign cmp = m_axis_tdata[2*DW];
    assign sat = m_axis_tdata[2*DW+1];
    assign dz  = m_axis_tdata[2*DW+2];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && cmp |-> re == '0 && im == '0 && !sat && !dz)
        else $error("compare result carries arithmetic fields");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && dz |-> re == '0 && im == '0 && !sat && !cmp)
        else $error("divide by zero result not cleared");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

// ----- sim/cau_checker.sv -----
module cau_tb_checker
    import cau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [IN_TW-1:0]  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [OUT_TW-1:0] i_out_data,
    output int                o_errors,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic          cmp;
        logic          sat;
        logic          dz;
    } t_cplx_res;

    t_cplx_res results_due[$];

    // Clip a signed value to the part range and flag the clip.
    function automatic logic [DW-1:0] clip_part(input longint v, inout logic sat);
        longint lo;
        longint hi;
        lo = -(longint'(1) << (DW - 1));
        hi = (longint'(1) << (DW - 1)) - 1;
        if (v > hi) begin
            sat = 1'b1;
            return hi[DW-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    // Numerator over divisor, truncated toward zero, fraction bits kept.
    function automatic longint div_part(input longint num, input longint d);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag << FRAC_BITS) / d;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint shr_part(input longint v);
        longint mag;
        mag = ((v < 0) ? -v : v) >> FRAC_BITS;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic t_cplx_res complex_result(input logic [IN_TW-1:0] word);
        t_cplx_res r;
        logic [OPW-1:0] op;
        longint ar, ai, br, bi, d;
        op = word[OPW-1:0];
        ar = longint'($signed(word[OPW +: DW]));
        ai = longint'($signed(word[OPW+DW +: DW]));
        br = longint'($signed(word[OPW+2*DW +: DW]));
        bi = longint'($signed(word[OPW+3*DW +: DW]));
        r = '{re: '0, im: '0, cmp: 1'b0, sat: 1'b0, dz: 1'b0};
        case (op)
            OP_ADD: begin
                r.re = clip_part(ar + br, r.sat);
                r.im = clip_part(ai + bi, r.sat);
            end
            OP_SUB: begin
                r.re = clip_part(ar - br, r.sat);
                r.im = clip_part(ai - bi, r.sat);
            end
            OP_MUL: begin
                r.re = clip_part(shr_part(ar * br - ai * bi), r.sat);
                r.im = clip_part(shr_part(ai * br + ar * bi), r.sat);
            end
            OP_DIV: begin
                d = br * br + bi * bi;
                if (d == 0) begin
                    r.dz = 1'b1;
                end else begin
                    r.re = clip_part(div_part(ar * br + ai * bi, d), r.sat);
                    r.im = clip_part(div_part(ai * br - ar * bi, d), r.sat);
                end
            end
            OP_EQ:   r.cmp = (ar == br) && (ai == bi);
            OP_NE:   r.cmp = (ar != br) || (ai != bi);
            default: ;
        endcase
        return r;
    endfunction

    assign o_pending = results_due.size();

    always @(posedge i_clk) begin
        t_cplx_res want;
        t_cplx_res got;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                results_due.push_back(complex_result(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got.re  = i_out_data[DW-1:0];
                got.im  = i_out_data[2*DW-1:DW];
                got.cmp = i_out_data[2*DW];
                got.sat = i_out_data[2*DW+1];
                got.dz  = i_out_data[2*DW+2];
                if (results_due.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result re=%h im=%h", got.re, got.im);
                    o_errors <= o_errors + 1;
                end else begin
                    want = results_due.pop_front();
                    if (got != want) begin
                        if (o_errors < 10)
                            $display({"mismatch: exp re=%h im=%h cmp=%b sat=%b dz=%b,",
                                      " got re=%h im=%h cmp=%b sat=%b dz=%b"},
                                     want.re, want.im, want.cmp, want.sat, want.dz,
                                     got.re, got.im, got.cmp, got.sat, got.dz);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    import cau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // op, a_re, a_im, b_re, b_im from the lowest bit up, zero pad
    logic [IN_TW-1:0]  s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // res_re, res_im, cmp_flag, saturated, div_zero from the lowest bit up, zero pad
    logic [OUT_TW-1:0] m_axis_tdata;

    int  errors;
    int  pending;
    bit  calm = 1'b0;   // no idling on either side in the closing stretch

    localparam logic [DW-1:0] PMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] NMAX = {1'b1, {(DW-1){1'b0}}};
    localparam int N_RANDOM = 1880;

    always #4 i_clk = ~i_clk;

    complex_arithmetic_unit DUT (.*);

    cau_tb_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Offer one operand pair, with an optional gap first, and hold it until the transfer.
    task automatic send_pair(input t_op op, input logic [DW-1:0] ar, input logic [DW-1:0] ai,
                             input logic [DW-1:0] br, input logic [DW-1:0] bi);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TW'({bi, br, ai, ar, op});
        @(posedge i_clk iff (s_axis_tvalid && s_axis_tready));
    endtask

    // Operand part: equally often full range, small so products stay in range, or extreme.
    function automatic logic [DW-1:0] pick_part();
        case ($urandom_range(0, 5))
            0:       return PMAX;
            1:       return NMAX;
            2, 3:    return DW'($signed($urandom_range(0, 2048)) - 1024);
            default: return DW'($urandom);
        endcase
    endfunction

    // Sink side: stall in random bursts until the closing stretch.
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    initial begin
        t_op op;
        logic [DW-1:0] ar, ai, br, bi;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of every operation, zero divisor, compares with one part differing.
        for (int k = 0; k < 6; k++) begin
            op = t_op'(k);
            send_pair(op, PMAX, PMAX, PMAX, PMAX);
            send_pair(op, NMAX, NMAX, NMAX, NMAX);
            send_pair(op, PMAX, NMAX, NMAX, PMAX);
        end
        send_pair(OP_DIV, 16'h0100, 16'h0200, '0, '0);
        send_pair(OP_DIV, NMAX, PMAX, 16'h0001, '0);
        send_pair(OP_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0100);
        send_pair(OP_MUL, 16'h0180, 16'hff80, 16'h0200, 16'h0040);
        send_pair(OP_EQ, 16'h1234, 16'h5678, 16'h1234, 16'h5678);
        send_pair(OP_EQ, 16'h1234, 16'h5678, 16'h1234, 16'h5679);
        send_pair(OP_NE, 16'h1234, 16'h5678, 16'h1235, 16'h5678);
        send_pair(OP_NE, 16'h1234, 16'h5678, 16'h1234, 16'h5678);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 200)
                calm = 1'b1;
            op = t_op'($urandom_range(0, 5));
            ar = pick_part();
            ai = pick_part();
            br = pick_part();
            bi = pick_part();
            // compares need equal parts now and then, divides a zero divisor now and then
            if ((op == OP_EQ || op == OP_NE) && $urandom_range(0, 1)) begin
                br = ar;
                if ($urandom_range(0, 1))
                    bi = ai;
            end
            if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
                br = '0;
                bi = '0;
            end
            send_pair(op, ar, ai, br, bi);
        end
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (25) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
